/* src/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the subpixel segment drawer
// Function codes, sequencer states, the write-control bundle passed from
// the sequencer to the top level, and the default strip length.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

    // Default number of pixels on the strip.
    localparam int STRIP_LENGTH_DEF = 256;

    // One pixel is three 8-bit channels, packed red, green, blue from the top.
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;

    // Function codes carried by an input item.
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Coverage of one whole pixel in 1/256 pixel units.
    localparam logic [15:0] FULL_COVER = 16'd256;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_BODY,
        ST_DRAIN,
        ST_READ,
        ST_RWAIT
    } t_state;

    // Write control for the strip memory.
    typedef struct packed {
        logic                clr;    // clearing sweep writes zero
        logic                valid;  // draw read-modify-write completes now
        logic                full;   // add the full color
        logic [CHAN_W-1:0]   scale;  // coverage scale for edge pixels
    } t_wr_ctl;

endpackage

`default_nettype wire

/* src/ssd_ram.sv */
// ----------------------------------------------------------------------------
// ssd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered, so it is
// available in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/ssd_pix.sv */
// ----------------------------------------------------------------------------
// ssd_pix: pixel update datapath
// Scales the segment color by the edge coverage and adds it to the stored
// pixel with per-channel saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_pix (
    input  wire logic [ssd_pkg::PIXEL_W-1:0] i_pixel,
    input  wire logic [ssd_pkg::PIXEL_W-1:0] i_color,
    input  wire logic                        i_full,
    input  wire logic [ssd_pkg::CHAN_W-1:0]  i_scale,
    output logic      [ssd_pkg::PIXEL_W-1:0] o_pixel
);

    import ssd_pkg::*;

    // Video-style scaling: a nonzero channel with a nonzero scale stays nonzero.
    function automatic logic [CHAN_W-1:0] video_scale(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] s
    );
        logic [2*CHAN_W-1:0] prod;
        logic [CHAN_W-1:0]   res;
        prod = c * s;
        if (c == '0) begin
            res = '0;
        end else begin
            res = prod[2*CHAN_W-1:CHAN_W] + CHAN_W'(s != '0);
        end
        return res;
    endfunction

    // Per-channel scale and saturating add.
    always_comb begin
        logic [CHAN_W-1:0] add_val;
        logic [CHAN_W:0]   sum;
        o_pixel = '0;
        for (int k = 0; k < 3; k++) begin
            add_val = i_full ? i_color[k*CHAN_W +: CHAN_W]
                             : video_scale(i_color[k*CHAN_W +: CHAN_W], i_scale);
            sum = {1'b0, i_pixel[k*CHAN_W +: CHAN_W]} + {1'b0, add_val};
            o_pixel[k*CHAN_W +: CHAN_W] = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/ssd_seq.sv */
// ----------------------------------------------------------------------------
// ssd_seq: item sequencer for the subpixel segment drawer
// Accepts items, walks a segment one pixel per cycle through a read stage
// and a write stage, sweeps the memory on reset and clear, and holds the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_seq #(
    parameter int STRIP_LENGTH = ssd_pkg::STRIP_LENGTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input item channel.
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_func,
    input  wire logic signed [23:0]              i_position,
    input  wire logic [15:0]                     i_length,
    input  wire logic [7:0]                      i_red,
    input  wire logic [7:0]                      i_green,
    input  wire logic [7:0]                      i_blue,
    input  wire logic [7:0]                      i_pixel_index,
    // Result item channel.
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_out_red,
    output logic [7:0]                           o_out_green,
    output logic [7:0]                           o_out_blue,
    // Strip memory access.
    input  wire logic [ssd_pkg::PIXEL_W-1:0]     i_rdata,
    output logic [$clog2(STRIP_LENGTH)-1:0]      o_raddr,
    output logic [$clog2(STRIP_LENGTH)-1:0]      o_waddr,
    output ssd_pkg::t_wr_ctl                     o_wr,
    output logic [ssd_pkg::PIXEL_W-1:0]          o_color
);

    import ssd_pkg::*;

    localparam int AW = $clog2(STRIP_LENGTH);
    localparam logic [AW:0]   LEN_CNT = (AW+1)'(STRIP_LENGTH);
    localparam logic [AW:0]   LAST    = (AW+1)'(STRIP_LENGTH - 1);
    localparam logic [23:0]   LIMIT   = 24'(STRIP_LENGTH * 256);
    localparam logic [AW+7:0] IDX_LIM = (AW+8)'(STRIP_LENGTH);

    // Coverage amount (1/256 pixel, at most 256) to scale: floor(a*255/256).
    function automatic logic [CHAN_W-1:0] amount_scale(input logic [8:0] a);
        logic [8:0] dec;
        dec = a - 9'd1;
        return (a == '0) ? '0 : dec[CHAN_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [AW:0]        r_idx, n_idx;
    logic [15:0]        r_rem, n_rem;
    logic [8:0]         r_first, n_first;
    logic [PIXEL_W-1:0] r_col, n_col;
    logic               r_rd_ok, n_rd_ok;
    logic               r_reply, n_reply;
    logic               r_out_valid, n_out_valid;
    logic [PIXEL_W-1:0] r_out_data, n_out_data;
    logic               r_op_valid, n_op_valid;
    logic [AW-1:0]      r_op_addr, n_op_addr;
    logic               r_op_full, n_op_full;
    logic [CHAN_W-1:0]  r_op_scale, n_op_scale;

    // Segment setup from the incoming item.
    logic [15:0]   start_i;
    logic          draw_ok;
    logic [8:0]    head_room;
    logic [8:0]    first_amt;
    logic [23:0]   end_sum;
    logic [23:0]   room_left;
    logic [15:0]   rem_total;
    logic [15:0]   rem_after;
    logic [AW+7:0] idx_ext;
    logic          idx_ok;

    always_comb begin
        start_i   = {1'b0, i_position[22:8]};
        draw_ok   = !i_position[23] && (start_i < 16'(STRIP_LENGTH)) && (i_length != '0);
        head_room = 9'd256 - {1'b0, i_position[7:0]};
        first_amt = ({7'b0, head_room} < i_length) ? head_room : i_length[8:0];
        end_sum   = {1'b0, i_position[22:0]} + {8'b0, i_length};
        room_left = LIMIT - {1'b0, i_position[22:0]};
        rem_total = (end_sum < LIMIT) ? i_length : room_left[15:0];
        rem_after = rem_total - {7'b0, first_amt};
        idx_ext   = {{AW{1'b0}}, i_pixel_index};
        idx_ok    = idx_ext < IDX_LIM;
    end

    // Next state, walker and result logic.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_first     = r_first;
        n_col       = r_col;
        n_rd_ok     = r_rd_ok;
        n_reply     = r_reply;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_op_valid  = 1'b0;
        n_op_addr   = r_idx[AW-1:0];
        n_op_full   = 1'b0;
        n_op_scale  = '0;
        o_in_stall  = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                    n_reply = 1'b0;
                    if (r_reply) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_stall = r_out_valid;
                if (i_in_valid && !r_out_valid) begin
                    n_col = {i_red, i_green, i_blue};
                    case (i_func)
                        FUNC_DRAW: begin
                            if (draw_ok) begin
                                n_state = ST_FIRST;
                                n_idx   = start_i[AW:0];
                                n_first = first_amt;
                                n_rem   = rem_after;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_idx   = '0;
                            n_reply = 1'b1;
                        end
                        FUNC_READ: begin
                            n_state = ST_READ;
                            n_idx   = idx_ext[AW:0];
                            n_rd_ok = idx_ok;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                        end
                    endcase
                end
            end
            ST_FIRST: begin
                // The first pixel always gets its partial coverage.
                n_op_valid = 1'b1;
                n_op_scale = amount_scale(r_first);
                n_idx      = r_idx + 1'b1;
                n_state    = ST_BODY;
            end
            ST_BODY: begin
                if (r_rem > FULL_COVER && r_idx < LEN_CNT) begin
                    n_op_valid = 1'b1;
                    n_op_full  = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    n_rem      = r_rem - FULL_COVER;
                end else if (r_rem != '0 && r_idx < LEN_CNT) begin
                    // Trailing pixel with the leftover coverage.
                    n_op_valid = 1'b1;
                    n_op_scale = amount_scale(r_rem[8:0]);
                    n_state    = ST_DRAIN;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last write of the segment completes in this cycle.
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_RWAIT;
            end
            ST_RWAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = r_rd_ok ? i_rdata : '0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
            r_op_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_reply     <= n_reply;
            r_out_valid <= n_out_valid;
            r_op_valid  <= n_op_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_first    <= n_first;
        r_col      <= n_col;
        r_rd_ok    <= n_rd_ok;
        r_out_data <= n_out_data;
        r_op_addr  <= n_op_addr;
        r_op_full  <= n_op_full;
        r_op_scale <= n_op_scale;
    end

    // Memory side: read the next pixel while the previous one is written.
    // The clearing sweep writes zero at the walk index.
    assign o_raddr    = r_idx[AW-1:0];
    assign o_waddr    = (r_state == ST_CLEAR) ? r_idx[AW-1:0] : r_op_addr;
    assign o_wr.clr   = (r_state == ST_CLEAR);
    assign o_wr.valid = r_op_valid;
    assign o_wr.full  = r_op_full;
    assign o_wr.scale = r_op_scale;
    assign o_color    = r_col;

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_data[3*CHAN_W-1:2*CHAN_W];
    assign o_out_green = r_out_data[2*CHAN_W-1:CHAN_W];
    assign o_out_blue  = r_out_data[CHAN_W-1:0];

endmodule

`default_nettype wire

/* src/subpixel_segment_draw.sv */
// ----------------------------------------------------------------------------
// subpixel_segment_draw: antialiased segment drawing into an RGB strip
// Strip memory with a pipelined read-modify-write path for segment drawing.
// ----------------------------------------------------------------------------
// The strip of STRIP_LENGTH RGB pixels lives in one dual-port RAM with a
// registered read, and every item gives exactly one result item. A draw
// walks the covered pixels at one read-modify-write per cycle (the read of
// the next pixel overlaps the write of the current one). A clear writes one
// pixel per cycle through the single RAM write port. After reset the block
// runs the same clearing pass before it accepts its first item. A new item
// is accepted only once the previous result item has been taken.
`default_nettype none

module subpixel_segment_draw #(
    parameter int STRIP_LENGTH = ssd_pkg::STRIP_LENGTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [23:0] i_position,
    input  wire logic [15:0]        i_length,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic [7:0]         i_pixel_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [7:0]              o_out_red,
    output logic [7:0]              o_out_green,
    output logic [7:0]              o_out_blue
);

    import ssd_pkg::*;

    localparam int AW = $clog2(STRIP_LENGTH);

    logic [PIXEL_W-1:0] rdata;
    logic [PIXEL_W-1:0] color;
    logic [PIXEL_W-1:0] upd_pixel;
    logic [PIXEL_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we;
    t_wr_ctl            wr;

    // Sequencer: item handshake, segment walker and result register.
    ssd_seq #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_length      (i_length),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_pixel_index (i_pixel_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .i_rdata       (rdata),
        .o_raddr       (raddr),
        .o_waddr       (waddr),
        .o_wr          (wr),
        .o_color       (color)
    );

    // Pixel update from the stored value read in the previous cycle.
    ssd_pix u_pix (
        .i_pixel (rdata),
        .i_color (color),
        .i_full  (wr.full),
        .i_scale (wr.scale),
        .o_pixel (upd_pixel)
    );

    // Clearing writes zero; drawing writes the updated pixel.
    assign we    = wr.clr | wr.valid;
    assign wdata = wr.clr ? '0 : upd_pixel;

    // Strip memory.
    ssd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STRIP_LENGTH)
    ) u_strip (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire
